[sv/cpd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package cpd_pkg;

  // point store geometry
  localparam int MAX_POINTS = 1024;
  localparam int ADDR_W     = $clog2(MAX_POINTS);
  localparam int CNT_W      = ADDR_W + 1;

  // field widths
  localparam int COORD_W = 16;
  localparam int POINT_W = 2 * COORD_W;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int SQ_W    = 2 * COORD_W;
  localparam int DIST_W  = 36;

  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  // controller states
  typedef enum logic [1:0] {
    S_LOAD,
    S_SEARCH,
    S_RESULT
  } cpd_state_t;

  // controller to datapath
  typedef struct packed {
    logic load_wr;       // store or drop the incoming point
    logic search_start;  // begin the pair sweep
    logic clear;         // result taken, restart the set
  } cpd_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic has_point;     // at least one point already stored
    logic busy;          // pair sweep or pipeline still active
  } cpd_stat_t;

endpackage

`default_nettype wire

[sv/cpd_if.sv]
`timescale 1ns / 1ps
`default_nettype none

// point channel
interface cpd_in_if;
  logic                valid;
  logic                ready;
  logic signed [15:0]  px;
  logic signed [15:0]  py;
  logic                last_point;

  modport source (output valid, px, py, last_point, input ready);
  modport sink   (input valid, px, py, last_point, output ready);
endinterface

// result channel
interface cpd_out_if;
  logic        valid;
  logic        ready;
  logic [35:0] min_dist_sq;
  logic        found;
  logic        overflowed;

  modport source (output valid, min_dist_sq, found, overflowed, input ready);
  modport sink   (input valid, min_dist_sq, found, overflowed, output ready);
endinterface

`default_nettype wire

[sv/cpd_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

module cpd_ctrl
  import cpd_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  input  wire logic      in_last,
  output logic           in_ready,
  output logic           out_valid,
  input  wire logic      out_ready,
  input  wire cpd_stat_t stat,
  output cpd_cmd_t       cmd
);

  cpd_state_t state_r, state_nxt;
  logic       in_acc;

  assign in_acc = in_valid && in_ready;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_LOAD: begin
        if (in_acc && in_last) begin
          state_nxt = stat.has_point ? S_SEARCH : S_RESULT;
        end
      end
      S_SEARCH: begin
        if (!stat.busy) begin
          state_nxt = S_RESULT;
        end
      end
      S_RESULT: begin
        if (out_ready) begin
          state_nxt = S_LOAD;
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  // outputs
  always_comb begin
    in_ready         = 1'b0;
    out_valid        = 1'b0;
    cmd.load_wr      = 1'b0;
    cmd.search_start = 1'b0;
    cmd.clear        = 1'b0;
    unique case (state_r)
      S_LOAD: begin
        in_ready         = 1'b1;
        cmd.load_wr      = in_valid;
        cmd.search_start = in_valid && in_last && stat.has_point;
      end
      S_SEARCH: begin
      end
      S_RESULT: begin
        out_valid = 1'b1;
        cmd.clear = out_ready;
      end
      default: begin
      end
    endcase
  end

`ifndef NO_ASSERTIONS
  // a search only starts from a load word
  a_start_from_load: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.search_start |-> (state_r == S_LOAD) && in_acc)
    else $error("search started outside load");

  // final word of a set always leads away from load
  a_last_leaves_load: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_last) |=> (state_r == S_SEARCH || state_r == S_RESULT))
    else $error("last point did not end the set");

  // search never ends while the datapath is still busy
  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SEARCH && stat.busy) |=> (state_r == S_SEARCH))
    else $error("result raised during search");
`endif

endmodule

`default_nettype wire

[sv/cpd_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none

module cpd_datapath
  import cpd_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire cpd_cmd_t            cmd,
  input  wire logic [COORD_W-1:0]  px,
  input  wire logic [COORD_W-1:0]  py,
  output cpd_stat_t                stat,
  output logic [DIST_W-1:0]        res_min,
  output logic                     res_found,
  output logic                     res_ovf
);

  // point store
  logic [POINT_W-1:0] store_mem [MAX_POINTS];

  logic [CNT_W-1:0]   cnt_r;
  logic               drop_r;
  logic [ADDR_W-1:0]  i_r, j_r;
  logic               pair_act_r;
  logic               v1_r, v2_r, v3_r;
  logic [POINT_W-1:0] pa_r, pb_r;
  logic signed [DIFF_W-1:0] dx_r, dy_r;
  logic [SQ_W-1:0]    sqx_r, sqy_r;
  logic [DIST_W-1:0]  best_r;

  logic                  full;
  logic                  last_j, last_i;
  logic [CNT_W-1:0]      i_plus2;
  logic signed [2*DIFF_W-1:0] prod_x, prod_y;
  logic [SQ_W:0]         sum;

  assign full    = (cnt_r == CNT_W'(MAX_POINTS));
  assign i_plus2 = CNT_W'(i_r) + CNT_W'(2);
  assign last_j  = (CNT_W'(j_r) + CNT_W'(1)) == cnt_r;
  assign last_i  = (i_plus2 == cnt_r);

  // store write and two registered reads
  always_ff @(posedge clk) begin
    if (cmd.load_wr && !full) begin
      store_mem[cnt_r[ADDR_W-1:0]] <= {py, px};
    end
    pa_r <= store_mem[i_r];
    pb_r <= store_mem[j_r];
  end

  // point count and drop flag
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      cnt_r  <= '0;
      drop_r <= 1'b0;
    end else if (cmd.load_wr) begin
      if (full) begin
        drop_r <= 1'b1;
      end else begin
        cnt_r <= cnt_r + CNT_W'(1);
      end
    end
  end

  // pair sweep: i over 0..n-2, j over i+1..n-1
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pair_act_r <= 1'b0;
      i_r        <= '0;
      j_r        <= '0;
    end else if (cmd.search_start) begin
      pair_act_r <= 1'b1;
      i_r        <= '0;
      j_r        <= ADDR_W'(1);
    end else if (pair_act_r) begin
      if (last_j) begin
        if (last_i) begin
          pair_act_r <= 1'b0;
        end else begin
          i_r <= i_r + ADDR_W'(1);
          j_r <= i_plus2[ADDR_W-1:0];
        end
      end else begin
        j_r <= j_r + ADDR_W'(1);
      end
    end
  end

  // pipeline valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= pair_act_r;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // coordinate differences
  always_ff @(posedge clk) begin
    dx_r <= $signed({pa_r[COORD_W-1], pa_r[COORD_W-1:0]})
          - $signed({pb_r[COORD_W-1], pb_r[COORD_W-1:0]});
    dy_r <= $signed({pa_r[POINT_W-1], pa_r[POINT_W-1:COORD_W]})
          - $signed({pb_r[POINT_W-1], pb_r[POINT_W-1:COORD_W]});
  end

  // squares, magnitude fits in SQ_W bits
  assign prod_x = dx_r * dx_r;
  assign prod_y = dy_r * dy_r;

  always_ff @(posedge clk) begin
    sqx_r <= prod_x[SQ_W-1:0];
    sqy_r <= prod_y[SQ_W-1:0];
  end

  // running minimum
  assign sum = {1'b0, sqx_r} + {1'b0, sqy_r};

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      best_r <= DIST_MAX;
    end else if (v3_r && (DIST_W'(sum) < best_r)) begin
      best_r <= DIST_W'(sum);
    end
  end

  // status and result
  assign stat.has_point = (cnt_r != '0);
  assign stat.busy      = pair_act_r || v1_r || v2_r || v3_r;

  assign res_found = (cnt_r >= CNT_W'(2));
  assign res_min   = res_found ? best_r : '0;
  assign res_ovf   = drop_r;

`ifndef NO_ASSERTIONS
  // sweep only touches stored entries, in increasing pair order
  a_pair_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    pair_act_r |-> (i_r < j_r) && (CNT_W'(j_r) < cnt_r))
    else $error("pair address outside stored points");

  // no point is written while the sweep runs
  a_no_load_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_wr |-> !stat.busy)
    else $error("point loaded during search");

  // count never passes capacity
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_POINTS))
    else $error("point count beyond capacity");

  // clear restores the running minimum and empties the set
  a_clear_best: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clear |=> (best_r == DIST_MAX) && (cnt_r == '0) && !drop_r)
    else $error("set state not cleared");
`endif

endmodule

`default_nettype wire

[sv/closest_pair_distance_core.sv]
// channel  dir  word fields                          handshake
// in_if    in   px[15:0] s, py[15:0] s, last_point   valid/ready
// out_if   out  min_dist_sq[35:0], found, overflowed valid/ready
//
// Ready is high whenever a set is being loaded, so a point is taken whenever one is offered.
// After the last point the sweep covers n*(n-1)/2 pairs at one pair a cycle,
// bounded by the single shared distance pipeline (read, difference, square, minimum).
// The result word is held until taken; no point is accepted while the search
// runs or the result waits. Reset (synchronous, active low) empties the set;
// store contents need no clearing since only counted entries are read.
`timescale 1ns / 1ps
`default_nettype none

module closest_pair_distance_core
  import cpd_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  cpd_in_if.sink     in_if,
  cpd_out_if.source  out_if
);

  cpd_cmd_t  cmd;
  cpd_stat_t stat;

  // sequencing
  cpd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_last   (in_if.last_point),
    .in_ready  (in_if.ready),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // store and distance pipeline
  cpd_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .px        (in_if.px),
    .py        (in_if.py),
    .stat      (stat),
    .res_min   (out_if.min_dist_sq),
    .res_found (out_if.found),
    .res_ovf   (out_if.overflowed)
  );

endmodule

`default_nettype wire
